// ===== sv/irc_pkg.sv =====
`default_nettype none

package irc_pkg;

   localparam int VAL_W     = 32;
   localparam int CNT_W     = 12;
   localparam int NUM_W     = 13;
   localparam int PAIR_W    = 23;
   localparam int INV_W     = 19;
   localparam int PAIRS_W   = 19;
   localparam int RATIO_W   = 17;
   localparam int DIV_STEPS = 17;
   localparam int STEP_W    = 5;

   // One item travelling down the cell chain.
   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic                    store;
      logic                    kept;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } irc_token_type;

   // Totals of one finished sequence, handed to the divider.
   typedef struct packed {
      logic              valid;
      logic [PAIR_W-1:0] inv;
      logic [NUM_W-1:0]  num;
      logic              drop;
   } irc_start_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MULT,
      DIV_STEP,
      DIV_HOLD
   } irc_div_state_type;

endpackage

`default_nettype wire

// ===== sv/irc_if.sv =====
`default_nettype none

interface irc_req_if import irc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic                    last;

   modport source (output valid, value, last, input ready);
   modport sink (input valid, value, last, output ready);
endinterface

interface irc_rsp_if import irc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INV_W-1:0]   inversions;
   logic [PAIRS_W-1:0] pairs;
   logic [RATIO_W-1:0] ratio;
   logic               too_few;
   logic               overflow;

   modport source (output valid, inversions, pairs, ratio, too_few, overflow, input ready);
   modport sink (input valid, inversions, pairs, ratio, too_few, overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/irc_cell.sv =====
`default_nettype none

module irc_cell import irc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire irc_token_type tok_in,
   output irc_token_type      tok_out
);

   logic                    slot_valid_ff;
   logic                    slot_valid_in;
   logic signed [VAL_W-1:0] slot_value_ff;
   logic signed [VAL_W-1:0] slot_value_in;
   irc_token_type           tok_ff;
   irc_token_type           tok_in_next;
   logic                    greater;
   logic                    place;

   assign greater = tok_in.valid && slot_valid_ff && (slot_value_ff > tok_in.value);
   assign place   = tok_in.valid && tok_in.store && !slot_valid_ff;

   always_comb begin
      tok_in_next       = tok_in;
      tok_in_next.count = tok_in.count + CNT_W'(greater);
      if (place) begin
         tok_in_next.store = 1'b0;
      end
      slot_value_in = place ? tok_in.value : slot_value_ff;
      slot_valid_in = slot_valid_ff || place;
      // The closing item of a sequence empties every slot it passes.
      if (tok_in.valid && tok_in.last) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         tok_ff.valid  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         tok_ff.valid  <= tok_in_next.valid;
      end
      slot_value_ff <= slot_value_in;
      tok_ff.last   <= tok_in_next.last;
      tok_ff.store  <= tok_in_next.store;
      tok_ff.kept   <= tok_in_next.kept;
      tok_ff.value  <= tok_in_next.value;
      tok_ff.count  <= tok_in_next.count;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ===== sv/irc_div.sv =====
`default_nettype none

module irc_div import irc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire irc_start_type start,
   irc_rsp_if.source          rsp_if
);

   irc_div_state_type  state_ff;
   irc_div_state_type  state_in;
   logic [PAIR_W-1:0]  inv_ff;
   logic [PAIR_W-1:0]  inv_in;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   num_in;
   logic               drop_ff;
   logic               drop_in;
   logic               few_ff;
   logic               few_in;
   logic [PAIR_W-1:0]  pairs_ff;
   logic [PAIR_W-1:0]  pairs_in;
   logic [PAIR_W:0]    rem_ff;
   logic [PAIR_W:0]    rem_in;
   logic [RATIO_W-1:0] quot_ff;
   logic [RATIO_W-1:0] quot_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [2*NUM_W-1:0] prod;
   logic               few;
   logic               ge;
   logic [PAIR_W:0]    diff;

   assign prod = (2*NUM_W)'(num_ff) * (2*NUM_W)'(num_ff - NUM_W'(1));
   assign few  = num_ff < NUM_W'(2);
   assign ge   = rem_ff >= {1'b0, pairs_ff};
   assign diff = ge ? (rem_ff - {1'b0, pairs_ff}) : rem_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start.valid) begin
               state_in = DIV_MULT;
            end
         end
         DIV_MULT: begin
            state_in = few ? DIV_HOLD : DIV_STEP;
         end
         DIV_STEP: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = DIV_HOLD;
            end
         end
         DIV_HOLD: begin
            if (rsp_if.ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   // Restoring division: the remainder never exceeds twice the divisor, so
   // each step is one compare and subtract giving one quotient bit.
   always_comb begin
      inv_in   = inv_ff;
      num_in   = num_ff;
      drop_in  = drop_ff;
      few_in   = few_ff;
      pairs_in = pairs_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            inv_in  = start.inv;
            num_in  = start.num;
            drop_in = start.drop;
         end
         DIV_MULT: begin
            few_in   = few;
            pairs_in = few ? '0 : PAIR_W'(prod >> 1);
            inv_in   = few ? '0 : inv_ff;
            rem_in   = {1'b0, inv_ff};
            quot_in  = '0;
            step_in  = '0;
         end
         DIV_STEP: begin
            rem_in  = diff << 1;
            quot_in = {quot_ff[RATIO_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
         end
         DIV_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      inv_ff   <= inv_in;
      num_ff   <= num_in;
      drop_ff  <= drop_in;
      few_ff   <= few_in;
      pairs_ff <= pairs_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
   end

   assign rsp_if.valid      = (state_ff == DIV_HOLD);
   assign rsp_if.inversions = INV_W'(inv_ff);
   assign rsp_if.pairs      = PAIRS_W'(pairs_ff);
   assign rsp_if.ratio      = quot_ff;
   assign rsp_if.too_few    = few_ff;
   assign rsp_if.overflow   = drop_ff;

   assert property (@(posedge clock) disable iff (reset)
      start.valid |-> state_ff == DIV_IDLE)
      else $error("sequence totals arrived while the divider was busy");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_HOLD && !few_ff |-> quot_ff <= RATIO_W'(1 << (RATIO_W - 1)))
      else $error("ratio above one");

endmodule

`default_nettype wire

// ===== sv/inversion_ratio_counter.sv =====
`default_nettype none
// Each accepted item walks down a chain of DEPTH cells, one cell a cycle.
// Items of a sequence are taken back to back; the last item passes the input register and DEPTH
// cells, then the divider captures the totals, runs a multiply step and a 17-step division, and
// offers the result; the division is skipped when fewer than two values were given.
// From the last item until its result is taken, no further item is accepted.
// Reset (synchronous, active high) empties every cell and clears the input and sequence counters.

module inversion_ratio_counter import irc_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   irc_req_if.sink   req_if,
   irc_rsp_if.source rsp_if
);

   irc_token_type     chain [DEPTH+1];
   irc_token_type     tok0_ff;
   irc_token_type     tok0_in;
   irc_token_type     tail;
   logic [NUM_W-1:0]  in_num_ff;
   logic [NUM_W-1:0]  in_num_in;
   logic              pending_ff;
   logic              pending_in;
   logic [PAIR_W-1:0] inv_acc_ff;
   logic [PAIR_W-1:0] inv_acc_in;
   logic [NUM_W-1:0]  num_acc_ff;
   logic [NUM_W-1:0]  num_acc_in;
   logic              drop_acc_ff;
   logic              drop_acc_in;
   irc_start_type     start;
   logic              accept;
   logic              room;

   assign req_if.ready = !pending_ff && !reset;
   assign accept       = req_if.valid && req_if.ready;
   assign room         = in_num_ff < NUM_W'(DEPTH);

   always_comb begin
      tok0_in.valid = accept;
      tok0_in.last  = req_if.last;
      tok0_in.store = room;
      tok0_in.kept  = room;
      tok0_in.value = req_if.value;
      tok0_in.count = '0;
      in_num_in     = in_num_ff;
      pending_in    = pending_ff;
      if (accept) begin
         in_num_in = req_if.last ? '0 : (in_num_ff + NUM_W'(room));
      end
      if (accept && req_if.last) begin
         pending_in = 1'b1;
      end else if (rsp_if.valid && rsp_if.ready) begin
         pending_in = 1'b0;
      end
   end

   assign chain[0] = tok0_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      irc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (chain[k]),
         .tok_out(chain[k+1])
      );
   end

   assign tail = chain[DEPTH];

   always_comb begin
      inv_acc_in  = inv_acc_ff;
      num_acc_in  = num_acc_ff;
      drop_acc_in = drop_acc_ff;
      if (tail.valid) begin
         if (tail.kept) begin
            inv_acc_in = inv_acc_ff + PAIR_W'(tail.count);
            num_acc_in = num_acc_ff + NUM_W'(1);
         end else begin
            drop_acc_in = 1'b1;
         end
      end
      start.valid = tail.valid && tail.last;
      start.inv   = inv_acc_in;
      start.num   = num_acc_in;
      start.drop  = drop_acc_in;
      if (start.valid) begin
         inv_acc_in  = '0;
         num_acc_in  = '0;
         drop_acc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
         in_num_ff     <= '0;
         pending_ff    <= 1'b0;
         inv_acc_ff    <= '0;
         num_acc_ff    <= '0;
         drop_acc_ff   <= 1'b0;
      end else begin
         tok0_ff.valid <= tok0_in.valid;
         in_num_ff     <= in_num_in;
         pending_ff    <= pending_in;
         inv_acc_ff    <= inv_acc_in;
         num_acc_ff    <= num_acc_in;
         drop_acc_ff   <= drop_acc_in;
      end
      tok0_ff.last  <= tok0_in.last;
      tok0_ff.store <= tok0_in.store;
      tok0_ff.kept  <= tok0_in.kept;
      tok0_ff.value <= tok0_in.value;
      tok0_ff.count <= tok0_in.count;
   end

   irc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (start),
      .rsp_if(rsp_if)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> pending_ff)
      else $error("result offered with no sequence outstanding");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_if.last |=> !req_if.ready && in_num_ff == '0)
      else $error("input side not closed after the last item");

   assert property (@(posedge clock) disable iff (reset)
      in_num_ff <= NUM_W'(DEPTH))
      else $error("stored count beyond the number of cells");

   assert property (@(posedge clock) disable iff (reset)
      tail.valid && tail.kept |-> NUM_W'(tail.count) < NUM_W'(DEPTH))
      else $error("item counted more greater values than cells exist");

endmodule

`default_nettype wire

// ===== sim/inversion_ratio_counter_tb.sv =====
`timescale 1ns / 1ps

module inversion_ratio_counter_tb import irc_pkg::*; ();

   localparam int DEPTH = 1024;
   // Far above the slowest legal run, stalls included.
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = DEPTH + 40;

   typedef struct packed {
      logic [INV_W-1:0]   inversions;
      logic [PAIRS_W-1:0] pairs;
      logic [RATIO_W-1:0] ratio;
      logic               too_few;
      logic               overflow;
   } seq_score_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
      logic                    given;
      seq_score_type           score;
   } probe_row_type;

   typedef enum int {
      SHAPE_MIXED,
      SHAPE_UP,
      SHAPE_DOWN
   } run_shape_type;

   localparam seq_score_type NO_SCORE = '0;

   // Short sequences whose scores can be worked out by hand; the last one is left
   // to the predictor.
   localparam probe_row_type PROBE_TABLE [21] = '{
      '{32'sh7FFFFFFF, 1'b1, 1'b1, '{19'd0, 19'd0, 17'd0, 1'b1, 1'b0}},
      '{32'sh80000000, 1'b1, 1'b1, '{19'd0, 19'd0, 17'd0, 1'b1, 1'b0}},
      '{32'sh7FFFFFFF, 1'b0, 1'b0, NO_SCORE},
      '{32'sh80000000, 1'b1, 1'b1, '{19'd1, 19'd1, 17'd65536, 1'b0, 1'b0}},
      '{32'sh80000000, 1'b0, 1'b0, NO_SCORE},
      '{32'sh7FFFFFFF, 1'b1, 1'b1, '{19'd0, 19'd1, 17'd0, 1'b0, 1'b0}},
      '{32'sd5,        1'b0, 1'b0, NO_SCORE},
      '{32'sd5,        1'b0, 1'b0, NO_SCORE},
      '{32'sd5,        1'b1, 1'b1, '{19'd0, 19'd3, 17'd0, 1'b0, 1'b0}},
      '{-32'sd1,       1'b0, 1'b0, NO_SCORE},
      '{32'sd1,        1'b0, 1'b0, NO_SCORE},
      '{32'sd0,        1'b1, 1'b1, '{19'd1, 19'd3, 17'd21845, 1'b0, 1'b0}},
      '{32'sd3,        1'b0, 1'b0, NO_SCORE},
      '{32'sd2,        1'b0, 1'b0, NO_SCORE},
      '{32'sd1,        1'b0, 1'b0, NO_SCORE},
      '{32'sd0,        1'b1, 1'b1, '{19'd6, 19'd6, 17'd65536, 1'b0, 1'b0}},
      '{32'sd1,        1'b0, 1'b0, NO_SCORE},
      '{-32'sd2,       1'b0, 1'b0, NO_SCORE},
      '{32'shAAAAAAAA, 1'b0, 1'b0, NO_SCORE},
      '{32'sh55555555, 1'b0, 1'b0, NO_SCORE},
      '{32'sd0,        1'b1, 1'b0, NO_SCORE}
   };

   localparam int PHASE_ITEMS [3] = '{280, 280, 1070};
   localparam int SEND_IDLE [3] = '{32, 49, 0};
   localparam int RSP_IDLE [3] = '{49, 32, 0};

   logic clock;
   logic reset;

   irc_req_if req_bus ();
   irc_rsp_if rsp_bus ();

   inversion_ratio_counter #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   int send_idle_pct = SEND_IDLE[0];
   int rsp_idle_pct = RSP_IDLE[0];
   int mismatch_count = 0;
   int cycle_count = 0;
   seq_score_type pending_scores [$];

   // Running state of the sequence under way, kept in step with the block.
   logic signed [VAL_W-1:0] held_values [DEPTH];
   int held_count = 0;
   int inv_running = 0;
   bit held_dropped = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic tally_value(input logic signed [VAL_W-1:0] v, input logic is_last,
                              output bit done, output seq_score_type s);
      int greater;
      longint n;
      longint pairs;
      longint ratio;
      greater = 0;
      s = '0;
      done = is_last;
      if (held_count < DEPTH) begin
         for (int k = 0; k < held_count; k++)
            if (held_values[k] > v) greater++;
         inv_running += greater;
         held_values[held_count] = v;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (is_last) begin
         n = held_count;
         if (n < 2) begin
            s.too_few = 1'b1;
         end else begin
            pairs = n * (n - 1) / 2;
            ratio = (longint'(inv_running) << 16) / pairs;
            s.inversions = INV_W'(inv_running);
            s.pairs = PAIRS_W'(pairs);
            s.ratio = RATIO_W'(ratio);
         end
         s.overflow = held_dropped;
         held_count = 0;
         inv_running = 0;
         held_dropped = 1'b0;
      end
   endtask

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(0, 3))
         0: return VAL_W'($urandom_range(0, 15)) - 8;
         1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                        : 32'sh80000000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Offers one item, waits until it is taken; a last item queues the expected score.
   task automatic send_item(input logic signed [VAL_W-1:0] v, input logic is_last,
                            input bit given, input seq_score_type typed);
      bit done;
      seq_score_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= $urandom;
         req_bus.last <= 1'($urandom_range(0, 1));
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      req_bus.last <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tally_value(v, is_last, done, predicted);
      if (done) pending_scores.push_back(given ? typed : predicted);
   endtask

   task automatic send_sequence(input int len, input run_shape_type shape,
                                input logic signed [VAL_W-1:0] start);
      logic signed [VAL_W-1:0] v;
      v = start;
      for (int i = 0; i < len; i++) begin
         if (i > 0) begin
            case (shape)
               SHAPE_UP:   v = v + $urandom_range(0, 1000);
               SHAPE_DOWN: v = v - $urandom_range(1, 1000);
               default:    v = random_value();
            endcase
         end
         send_item(v, i == len - 1, 1'b0, NO_SCORE);
      end
   endtask

   // Holds the sender back until every outstanding score has been returned.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
   endtask

   task automatic check_score();
      seq_score_type want;
      if (pending_scores.size() == 0) begin
         report_mismatch("unexpected result", rsp_bus.inversions, 0);
         return;
      end
      want = pending_scores.pop_front();
      if (rsp_bus.inversions !== want.inversions)
         report_mismatch("inversions", rsp_bus.inversions, want.inversions);
      if (rsp_bus.pairs !== want.pairs)
         report_mismatch("pairs", rsp_bus.pairs, want.pairs);
      if (rsp_bus.ratio !== want.ratio)
         report_mismatch("ratio", rsp_bus.ratio, want.ratio);
      if (rsp_bus.too_few !== want.too_few)
         report_mismatch("too_few", rsp_bus.too_few, want.too_few);
      if (rsp_bus.overflow !== want.overflow)
         report_mismatch("overflow", rsp_bus.overflow, want.overflow);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_score();
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int sent;
      int len;
      int pick;
      run_shape_type shape;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (PROBE_TABLE[i])
         send_item(PROBE_TABLE[i].value, PROBE_TABLE[i].last, PROBE_TABLE[i].given,
                   PROBE_TABLE[i].score);
      drain_results();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = SEND_IDLE[ph];
         rsp_idle_pct = RSP_IDLE[ph];
         sent = 0;
         if (ph == 2) begin
            // A strictly falling run past the store's end: every pair is an inversion,
            // and the final item, which carries last, is itself dropped.
            send_sequence(DEPTH + 2, SHAPE_DOWN, 32'sh7FFFFFFF);
            sent += DEPTH + 2;
         end
         while (sent < PHASE_ITEMS[ph]) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 80)
                                                : $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            shape = (pick < 6) ? SHAPE_MIXED : (pick < 8) ? SHAPE_UP : SHAPE_DOWN;
            send_sequence(len, shape, random_value());
            sent += len;
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
